@@ hw/rtl/awb_pkg.sv @@
package awb_pkg;

    // Image limits and derived widths
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 8;
    localparam int BANK_AW    = (ROW_W - 1) + (COL_W - 1);
    localparam int BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);

    // Fixed point widths
    localparam int COEF_W = 24;
    localparam int SHFT_W = 32;
    localparam int PROD_W = COEF_W + 9;
    localparam int POS_W  = PROD_W + 2;
    localparam int FRAC_W = 16;
    localparam int BASE_W = POS_W - FRAC_W;
    localparam int PIX_W  = 8;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_INV_XX  = 3'd0,
        REG_INV_XY  = 3'd1,
        REG_INV_YX  = 3'd2,
        REG_INV_YY  = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_WIDTH   = 3'd6,
        REG_HEIGHT  = 3'd7
    } awb_reg_t;

    // Request kinds on the input channel
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } awb_op_t;

    // Control that travels with each request down the pipeline
    typedef struct packed {
        logic vld;
        logic qry;
    } awb_ctl_t;

endpackage

@@ hw/rtl/awb_map.sv @@
module awb_map (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 adv,
    input  awb_pkg::awb_ctl_t                    in_ctl,
    input  logic [awb_pkg::ROW_W-1:0]            in_row,
    input  logic [awb_pkg::COL_W-1:0]            in_col,
    input  logic [awb_pkg::PIX_W-1:0]            in_pixel,
    input  logic signed [awb_pkg::COEF_W-1:0]    inv_xx,
    input  logic signed [awb_pkg::COEF_W-1:0]    inv_xy,
    input  logic signed [awb_pkg::COEF_W-1:0]    inv_yx,
    input  logic signed [awb_pkg::COEF_W-1:0]    inv_yy,
    input  logic signed [awb_pkg::SHFT_W-1:0]    shift_x,
    input  logic signed [awb_pkg::SHFT_W-1:0]    shift_y,
    output awb_pkg::awb_ctl_t                    out_ctl,
    output logic [awb_pkg::ROW_W-1:0]            out_row,
    output logic [awb_pkg::COL_W-1:0]            out_col,
    output logic [awb_pkg::PIX_W-1:0]            out_pixel,
    output logic signed [awb_pkg::POS_W-1:0]     out_x,
    output logic signed [awb_pkg::POS_W-1:0]     out_y
);
    import awb_pkg::*;

    awb_ctl_t                 ctl1_reg, ctl2_reg;
    logic [ROW_W-1:0]         row1_reg, row2_reg;
    logic [COL_W-1:0]         col1_reg, col2_reg;
    logic [PIX_W-1:0]         pix1_reg, pix2_reg;
    logic signed [PROD_W-1:0] pxx_reg, pxy_reg, pyx_reg, pyy_reg;
    logic signed [PROD_W-1:0] pxx_next, pxy_next, pyx_next, pyy_next;
    logic signed [8:0]        cx_odd, cy_odd;
    logic signed [PROD_W:0]   sx, sy;
    logic signed [POS_W-1:0]  x_next, y_next, x_reg, y_reg;

    function automatic logic [7:0] col_odd_bits(input logic [COL_W-1:0] c);
        return {c, 1'b1};
    endfunction

    function automatic logic [7:0] row_odd_bits(input logic [ROW_W-1:0] r);
        return {r, 1'b1};
    endfunction

    // Pixel centre in half-pixel units: 2*col+1, 2*row+1
    assign cx_odd = $signed({1'b0, col_odd_bits(in_col)});
    assign cy_odd = $signed({1'b0, row_odd_bits(in_row)});

    // Stage 1: coefficient products
    assign pxx_next = inv_xx * cx_odd;
    assign pxy_next = inv_xy * cy_odd;
    assign pyx_next = inv_yx * cx_odd;
    assign pyy_next = inv_yy * cy_odd;

    // Stage 2: sum, halve with floor, translate and take off half a pixel
    assign sx     = pxx_reg + pxy_reg;
    assign sy     = pyx_reg + pyy_reg;
    assign x_next = (sx >>> 1) + shift_x - 35'sd32768;
    assign y_next = (sy >>> 1) + shift_y - 35'sd32768;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else if (adv) begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            row1_reg <= in_row;
            col1_reg <= in_col;
            pix1_reg <= in_pixel;
            pxx_reg  <= pxx_next;
            pxy_reg  <= pxy_next;
            pyx_reg  <= pyx_next;
            pyy_reg  <= pyy_next;
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
            pix2_reg <= pix1_reg;
            x_reg    <= x_next;
            y_reg    <= y_next;
        end
    end

    assign out_ctl   = ctl2_reg;
    assign out_row   = row2_reg;
    assign out_col   = col2_reg;
    assign out_pixel = pix2_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

@@ hw/rtl/awb_fetch.sv @@
module awb_fetch (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic [awb_pkg::DIM_W-1:0]          eff_w,
    input  logic [awb_pkg::DIM_W-1:0]          eff_h,
    input  awb_pkg::awb_ctl_t                  in_ctl,
    input  logic [awb_pkg::ROW_W-1:0]          in_row,
    input  logic [awb_pkg::COL_W-1:0]          in_col,
    input  logic [awb_pkg::PIX_W-1:0]          in_pixel,
    input  logic signed [awb_pkg::POS_W-1:0]   in_x,
    input  logic signed [awb_pkg::POS_W-1:0]   in_y,
    output awb_pkg::awb_ctl_t                  out_ctl,
    output logic [3:0][awb_pkg::PIX_W-1:0]     out_nb,
    output logic [awb_pkg::FRAC_W-1:0]         out_fx,
    output logic [awb_pkg::FRAC_W-1:0]         out_fy
);
    import awb_pkg::*;

    // Four banks split by row parity (upper index bit) and column parity
    logic [PIX_W-1:0] mem [4][BANK_DEPTH];

    logic signed [BASE_W:0] r0, r1, c0, c1;
    logic signed [BASE_W:0] rsel [4];
    logic signed [BASE_W:0] csel [4];
    logic [BANK_AW-1:0]     raddr [4];
    logic [3:0]             ok_next, ok_reg;
    logic [3:0]             wen;
    logic [BANK_AW-1:0]     waddr;
    logic                   load_ok;
    logic [PIX_W-1:0]       q_reg [4];
    awb_ctl_t               ctl_next, ctl_reg;
    logic                   br0_reg, bc0_reg;
    logic [FRAC_W-1:0]      fx_reg, fy_reg;

    function automatic logic in_rng(input logic signed [BASE_W:0] v,
                                    input logic [DIM_W-1:0] lim);
        return !v[BASE_W] && (v[BASE_W-1:0] < {{(BASE_W-DIM_W){1'b0}}, lim});
    endfunction

    // Base pixel and its neighbor one step down or right
    assign r0 = {in_y[POS_W-1], in_y[POS_W-1:FRAC_W]};
    assign c0 = {in_x[POS_W-1], in_x[POS_W-1:FRAC_W]};
    assign r1 = r0 + $signed((BASE_W+1)'(1));
    assign c1 = c0 + $signed((BASE_W+1)'(1));

    // Pick per bank the neighbor of matching parity and check bounds
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            rsel[b]    = (r0[0] == b[1]) ? r0 : r1;
            csel[b]    = (c0[0] == b[0]) ? c0 : c1;
            raddr[b]   = {rsel[b][ROW_W-1:1], csel[b][COL_W-1:1]};
            ok_next[b] = in_ctl.vld && in_ctl.qry
                         && in_rng(rsel[b], eff_h) && in_rng(csel[b], eff_w);
        end
    end

    // Loads write one bank if inside the image
    assign load_ok = in_ctl.vld && !in_ctl.qry
                     && ({1'b0, in_row} < eff_h) && ({1'b0, in_col} < eff_w);
    assign waddr   = {in_row[ROW_W-1:1], in_col[COL_W-1:1]};

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            wen[b] = adv && load_ok && (in_row[0] == b[1]) && (in_col[0] == b[0]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int b = 0; b < 4; b++) begin
            if (wen[b]) begin
                mem[b][waddr] <= in_pixel;
            end
            if (adv) begin
                q_reg[b] <= mem[b][raddr[b]];
            end
        end
    end

    // Only queries go on past this stage
    always_comb begin
        ctl_next     = in_ctl;
        ctl_next.vld = in_ctl.vld && in_ctl.qry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
            ok_reg  <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_next;
            ok_reg  <= ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            br0_reg <= r0[0];
            bc0_reg <= c0[0];
            fx_reg  <= in_x[FRAC_W-1:0];
            fy_reg  <= in_y[FRAC_W-1:0];
        end
    end

    // Order neighbors as {down, right}; drop those outside the image
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            logic [1:0] bk;
            bk = {br0_reg ^ n[1], bc0_reg ^ n[0]};
            out_nb[n] = ok_reg[bk] ? q_reg[bk] : '0;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_fx  = fx_reg;
    assign out_fy  = fy_reg;

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(wen))
        else $error("more than one bank written in a cycle");
    a_ok_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (|ok_reg) |-> (ctl_reg.vld && ctl_reg.qry))
        else $error("neighbor marked valid for a non-query");
    a_reset_idle: assert property (@(posedge aclk) $past(!aresetn) |-> !ctl_reg.vld)
        else $error("valid request after reset");

endmodule

@@ hw/rtl/awb_blend.sv @@
module awb_blend (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  awb_pkg::awb_ctl_t              in_ctl,
    input  logic [3:0][awb_pkg::PIX_W-1:0] in_nb,
    input  logic [awb_pkg::FRAC_W-1:0]     in_fx,
    input  logic [awb_pkg::FRAC_W-1:0]     in_fy,
    output logic                           out_valid,
    output logic [awb_pkg::PIX_W-1:0]      out_pixel
);
    import awb_pkg::*;

    localparam int H_W = PIX_W + FRAC_W;
    localparam int M_W = H_W + FRAC_W + 1;

    logic [FRAC_W:0]   gx, gy_next, gy_reg;
    logic [FRAC_W-1:0] fy_reg;
    logic [H_W-1:0]    h0_next, h1_next, h0_reg, h1_reg;
    logic [M_W-1:0]    m0_reg, m1_reg;
    logic [M_W:0]      total;
    logic              v1_reg, v2_reg, v3_reg;
    logic [PIX_W-1:0]  pix_reg;

    // Horizontal blend of each row pair
    assign gx      = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, in_fx};
    assign gy_next = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, in_fy};
    assign h0_next = H_W'(in_nb[0] * gx) + H_W'(in_nb[1] * in_fx);
    assign h1_next = H_W'(in_nb[2] * gx) + H_W'(in_nb[3] * in_fx);
    assign total   = {1'b0, m0_reg} + {1'b0, m1_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_ctl.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Vertical blend, then keep the integer byte
    always_ff @(posedge aclk) begin
        if (adv) begin
            h0_reg  <= h0_next;
            h1_reg  <= h1_next;
            gy_reg  <= gy_next;
            fy_reg  <= in_fy;
            m0_reg  <= M_W'(h0_reg * gy_reg);
            m1_reg  <= M_W'(h1_reg * fy_reg);
            pix_reg <= total[2*FRAC_W +: PIX_W];
        end
    end

    assign out_valid = v3_reg;
    assign out_pixel = pix_reg;

endmodule

@@ hw/rtl/affine_warp_bilinear.sv @@
// Affine warp with bilinear interpolation over an 8-bit grayscale image.
// Input stream: s_tuser is the kind of request (0 load, 1 query), s_tdata
// holds row, col and the source pixel. A load writes the source image and
// returns nothing; a query returns one warped pixel on the m_ stream.
// Load the whole image before sending queries that read it.
// Configuration: write cfg_wdata to register cfg_addr while the block idles;
// registers are the inverse matrix (Q8.16), the shift (Q16.16) and the
// image size, clamped to 128.
// Throughput is one request per cycle unless the receiver stalls; the source
// image sits in four banks split by row and column parity, so the four
// neighbors are read in the same cycle.
// Reset puts the registers to identity and 128x128 and empties the
// pipeline; image contents are undefined until loaded.
// When the receiver stalls a result, the whole pipeline holds and s_tready
// drops in the same cycle; nothing is lost or repeated.
module affine_warp_bilinear (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // row[6:0], col[13:7], pixel[21:14], zero
    input  logic        s_tuser,    // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // pixel_out[7:0]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import awb_pkg::*;

    logic signed [COEF_W-1:0] inv_xx_reg, inv_xy_reg, inv_yx_reg, inv_yy_reg;
    logic signed [SHFT_W-1:0] shift_x_reg, shift_y_reg;
    logic [DIM_W-1:0]         width_reg, height_reg, eff_w, eff_h;
    logic                     adv;
    awb_ctl_t                 in_ctl, map_ctl, fch_ctl;
    logic [ROW_W-1:0]         map_row;
    logic [COL_W-1:0]         map_col;
    logic [PIX_W-1:0]         map_pix;
    logic signed [POS_W-1:0]  map_x, map_y;
    logic [3:0][PIX_W-1:0]    nb;
    logic [FRAC_W-1:0]        fx, fy;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_xx_reg  <= 24'sd65536;
            inv_xy_reg  <= '0;
            inv_yx_reg  <= '0;
            inv_yy_reg  <= 24'sd65536;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            width_reg   <= 8'd128;
            height_reg  <= 8'd128;
        end else if (cfg_wr_en) begin
            unique case (awb_reg_t'(cfg_addr))
                REG_INV_XX:  inv_xx_reg  <= cfg_wdata[COEF_W-1:0];
                REG_INV_XY:  inv_xy_reg  <= cfg_wdata[COEF_W-1:0];
                REG_INV_YX:  inv_yx_reg  <= cfg_wdata[COEF_W-1:0];
                REG_INV_YY:  inv_yy_reg  <= cfg_wdata[COEF_W-1:0];
                REG_SHIFT_X: shift_x_reg <= cfg_wdata;
                REG_SHIFT_Y: shift_y_reg <= cfg_wdata;
                REG_WIDTH:   width_reg   <= cfg_wdata[DIM_W-1:0];
                REG_HEIGHT:  height_reg  <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the image size to the storage
    assign eff_w = (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign eff_h = (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;

    // Advance everything unless a finished result waits
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    assign in_ctl = '{vld: s_tvalid && adv, qry: (awb_op_t'(s_tuser) == OP_QUERY)};

    awb_map u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_ctl    (in_ctl),
        .in_row    (s_tdata[6:0]),
        .in_col    (s_tdata[13:7]),
        .in_pixel  (s_tdata[21:14]),
        .inv_xx    (inv_xx_reg),
        .inv_xy    (inv_xy_reg),
        .inv_yx    (inv_yx_reg),
        .inv_yy    (inv_yy_reg),
        .shift_x   (shift_x_reg),
        .shift_y   (shift_y_reg),
        .out_ctl   (map_ctl),
        .out_row   (map_row),
        .out_col   (map_col),
        .out_pixel (map_pix),
        .out_x     (map_x),
        .out_y     (map_y)
    );

    awb_fetch u_fetch (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .in_ctl   (map_ctl),
        .in_row   (map_row),
        .in_col   (map_col),
        .in_pixel (map_pix),
        .in_x     (map_x),
        .in_y     (map_y),
        .out_ctl  (fch_ctl),
        .out_nb   (nb),
        .out_fx   (fx),
        .out_fy   (fy)
    );

    awb_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_ctl    (fch_ctl),
        .in_nb     (nb),
        .in_fx     (fx),
        .in_fy     (fy),
        .out_valid (m_tvalid),
        .out_pixel (m_tdata)
    );

    a_reset_quiet: assert property (@(posedge aclk) $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");
    a_stall_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !in_ctl.vld)
        else $error("request taken while output stalled");
    a_eff_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        (eff_w <= DIM_W'(MAX_WIDTH)) && (eff_h <= DIM_W'(MAX_HEIGHT)))
        else $error("effective size above storage");

endmodule
